/* hw/rtl/ffud_pkg.sv */
// Shared package for the form field extractor with URL decoding.
// Holds character codes, buffer sizing, result and config types, and the hex and put_byte helpers.
// No dependencies.
package ffud_pkg;

    localparam int KEY_MAX   = 8;
    localparam int RES_MAX   = 3;
    localparam int OB_DEPTH  = 8;
    localparam int OB_AW     = $clog2(OB_DEPTH);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration register indexes.
    localparam logic CFG_KEY_BYTES  = 1'b0;
    localparam logic CFG_KEY_LENGTH = 1'b1;

    typedef struct packed {
        logic [63:0] key_bytes;
        logic [3:0]  key_length;
    } t_cfg;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       found;
        logic       done_res;
    } t_res_item;

    typedef struct packed {
        logic [1:0]                count;
        t_res_item [RES_MAX-1:0]   item;
    } t_res_set;

    typedef struct packed {
        logic             space;
        logic [OB_AW:0]   count;
    } t_buf_status;

    // Returns {valid, nibble}.
    function automatic logic [4:0] hex_val(logic [7:0] c);
        logic [4:0] r;
        r = 5'b0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic t_res_set put_byte(t_res_set s, logic [7:0] b);
        t_res_set r;
        r = s;
        r.item[s.count] = '{out_byte: b, byte_valid: 1'b1, found: 1'b0, done_res: 1'b0};
        r.count = s.count + 2'd1;
        return r;
    endfunction

endpackage

/* hw/rtl/ffud_decode.sv */
// Segment parser, key matcher and URL decoder for one body byte per cycle.
// Depends on ffud_pkg; produces up to RES_MAX results for the output buffer.
module ffud_decode
    import ffud_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_end,
    output t_res_set   o_res
);

    typedef enum logic [1:0] {
        PH_KEY      = 2'd0,
        PH_VALUE    = 2'd1,
        PH_SKIP     = 2'd2,
        PH_FINISHED = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ESC_NONE  = 2'd0,
        ESC_PCT   = 2'd1,
        ESC_DIGIT = 2'd2
    } t_esc;

    t_phase     r_phase, n_phase;
    logic [3:0] r_key_index, n_key_index;
    logic       r_key_mismatch, n_key_mismatch;
    t_esc       r_esc, n_esc;
    logic [7:0] r_held, n_held;

    function automatic t_res_set flush_esc(t_res_set s, t_esc esc, logic [7:0] held);
        t_res_set r;
        r = s;
        if (esc == ESC_PCT) begin
            r = put_byte(r, CH_PCT);
        end else if (esc == ESC_DIGIT) begin
            r = put_byte(r, CH_PCT);
            r = put_byte(r, held);
        end
        return r;
    endfunction

    always_comb begin
        logic [3:0] eff;
        logic [4:0] hx;
        logic [4:0] hx_hi;
        logic       cont;
        logic       found;
        t_res_set   res;

        n_phase        = r_phase;
        n_key_index    = r_key_index;
        n_key_mismatch = r_key_mismatch;
        n_esc          = r_esc;
        n_held         = r_held;
        res            = '0;
        cont           = 1'b1;
        found          = 1'b0;
        eff   = (i_cfg.key_length > 4'(KEY_MAX)) ? 4'(KEY_MAX) : i_cfg.key_length;
        hx    = hex_val(i_byte);
        hx_hi = hex_val(r_held);

        if (i_valid) begin
            unique case (r_phase)
                PH_KEY: begin
                    if (i_byte == CH_AMP) begin
                        n_key_index    = 4'd0;
                        n_key_mismatch = 1'b0;
                    end else if (i_byte == CH_EQ) begin
                        n_phase = (!r_key_mismatch && r_key_index == eff) ? PH_VALUE
                                                                          : PH_SKIP;
                    end else begin
                        // Index past the key length means the segment key is longer.
                        if (r_key_index >= eff ||
                            i_cfg.key_bytes[{r_key_index[2:0], 3'b000} +: 8] != i_byte) begin
                            n_key_mismatch = 1'b1;
                        end
                        if (r_key_index != 4'hF) begin
                            n_key_index = r_key_index + 4'd1;
                        end
                    end
                end
                PH_SKIP: begin
                    if (i_byte == CH_AMP) begin
                        n_phase        = PH_KEY;
                        n_key_index    = 4'd0;
                        n_key_mismatch = 1'b0;
                    end
                end
                PH_VALUE: begin
                    if (r_esc == ESC_PCT) begin
                        if (hx[4]) begin
                            n_held = i_byte;
                            n_esc  = ESC_DIGIT;
                            cont   = 1'b0;
                        end else begin
                            res   = put_byte(res, CH_PCT);
                            n_esc = ESC_NONE;
                        end
                    end else if (r_esc == ESC_DIGIT) begin
                        if (hx[4]) begin
                            res   = put_byte(res, {hx_hi[3:0], hx[3:0]});
                            cont  = 1'b0;
                        end else begin
                            res = put_byte(res, CH_PCT);
                            res = put_byte(res, r_held);
                        end
                        n_esc  = ESC_NONE;
                        n_held = 8'h00;
                    end
                    if (cont) begin
                        if (i_byte == CH_PCT) begin
                            n_esc = ESC_PCT;
                        end else if (i_byte == CH_AMP) begin
                            n_phase = PH_FINISHED;
                        end else if (i_byte == CH_PLUS) begin
                            res = put_byte(res, CH_SPACE);
                        end else begin
                            res = put_byte(res, i_byte);
                        end
                    end
                    if (n_phase == PH_FINISHED) begin
                        res    = flush_esc(res, n_esc, n_held);
                        n_esc  = ESC_NONE;
                        n_held = 8'h00;
                    end
                end
                PH_FINISHED: begin
                end
                default: begin
                end
            endcase

            if (i_end) begin
                if (n_phase == PH_VALUE) begin
                    res = flush_esc(res, n_esc, n_held);
                end
                found = (n_phase == PH_VALUE) || (n_phase == PH_FINISHED);
                // A byte with no output of its own still yields an empty done result.
                if (res.count == 2'd0) begin
                    res.item[0] = '0;
                    res.count   = 2'd1;
                end
                res.item[res.count - 2'd1].found    = found;
                res.item[res.count - 2'd1].done_res = 1'b1;
                n_phase        = PH_KEY;
                n_key_index    = 4'd0;
                n_key_mismatch = 1'b0;
                n_esc          = ESC_NONE;
                n_held         = 8'h00;
            end
        end
        o_res = res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_KEY;
            r_key_index    <= 4'd0;
            r_key_mismatch <= 1'b0;
            r_esc          <= ESC_NONE;
            r_held         <= 8'h00;
        end else begin
            r_phase        <= n_phase;
            r_key_index    <= n_key_index;
            r_key_mismatch <= n_key_mismatch;
            r_esc          <= n_esc;
            r_held         <= n_held;
        end
    end

endmodule

/* hw/rtl/ffud_outbuf.sv */
// Result buffer: takes up to RES_MAX results per cycle, sends one per cycle while the receiver is ready.
// Depends on ffud_pkg.
module ffud_outbuf
    import ffud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_res_set    i_res,
    input  logic        i_m_tready,
    output logic        o_m_tvalid,
    output t_res_item   o_head,
    output t_buf_status o_status
);

    t_res_item [OB_DEPTH-1:0] r_mem;
    logic [OB_AW-1:0]         r_wr_ptr, r_rd_ptr;
    logic [OB_AW:0]           r_count;
    logic                     pop;

    assign o_m_tvalid      = (r_count != '0);
    assign o_head          = r_mem[r_rd_ptr];
    assign pop             = o_m_tvalid && i_m_tready;
    assign o_status.space  = (r_count <= (OB_AW+1)'(OB_DEPTH - RES_MAX));
    assign o_status.count  = r_count;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RES_MAX; k++) begin
            if (2'(k) < i_res.count) begin
                r_mem[r_wr_ptr + OB_AW'(k)] <= i_res.item[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OB_AW'(i_res.count);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + OB_AW'(1);
            end
            r_count <= r_count + (OB_AW+1)'(i_res.count) - (OB_AW+1)'(pop);
        end
    end

endmodule

/* hw/rtl/form_field_extract_url_decode_top.sv */
// Top level of the form field extractor with URL decoding.
// Depends on ffud_pkg, ffud_decode and ffud_outbuf.
//
// Channel   Direction  Data                                  Marks
// s_axis    in         tdata[7:0] body_byte                  tlast = body_end
// m_axis    out        tdata[7:0] out_byte, [8] found        tuser = byte_valid, tlast = done_res
// cfg       in         index 0 key_bytes, 1 key_length       write enable, no read-back
//
// One body byte is taken per cycle while there is space; it is registered before decoding.
// A byte yields up to three results, sent one per cycle from an eight-entry buffer.
// The input register advances only while the buffer has three free entries, so a
// stalled output or a burst of escape flushes holds o_s_axis_tready low.
// Reset is synchronous and active low; it clears the parser and empties the buffer.
module form_field_extract_url_decode_top
    import ffud_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] body_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [7:0] out_byte, [8] found, [15:9] zero
    output logic        o_m_axis_tuser,   // [0] byte_valid
    output logic        o_m_axis_tlast
);

    t_cfg        r_cfg;
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;
    logic        advance;
    t_res_set    res;
    t_res_item   head;
    t_buf_status status;

    assign advance         = r_in_valid && status.space;
    assign o_s_axis_tready = !r_in_valid || status.space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_KEY_BYTES:  r_cfg.key_bytes  <= i_cfg_data;
                CFG_KEY_LENGTH: r_cfg.key_length <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_end  <= i_s_axis_tlast;
        end
    end

    ffud_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (advance),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_res   (res)
    );

    ffud_outbuf u_outbuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_head     (head),
        .o_status   (status)
    );

    assign o_m_axis_tdata = {7'b0, head.found, head.out_byte};
    assign o_m_axis_tuser = head.byte_valid;
    assign o_m_axis_tlast = head.done_res;

    // The buffer can never hold more than its depth.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.count <= (OB_AW+1)'(OB_DEPTH))
        else $error("result buffer overflow");

    // A request waiting for buffer space is held unchanged.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !status.space) |=> (r_in_valid && $stable(r_in_byte)
                                           && $stable(r_in_end)))
        else $error("stalled input request lost");

    // Results are only produced for a byte that is being processed.
    a_res_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.count != 2'd0) |-> advance)
        else $error("result without an input byte");

    // The buffer fill follows writes and reads exactly.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> status.count == $past(status.count + (OB_AW+1)'(res.count)
                                      - (OB_AW+1)'(o_m_axis_tvalid && i_m_axis_tready)))
        else $error("result buffer count mismatch");

endmodule
